>>> rtl/core/quality_run_fragment_filter_assert.svh
// Assertion macros for the quality run fragment filter.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef QUALITY_RUN_FRAGMENT_FILTER_ASSERT_SVH
`define QUALITY_RUN_FRAGMENT_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define QRFF_ASSERT_IMPL(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error("qrff: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define QRFF_ASSERT_NEXT(name, clk, rstn, pre, post) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("qrff: next-cycle check failed");

`endif

>>> rtl/core/qrff_pkg.sv
// Shared types, constants and helpers for the quality run fragment filter.
// No dependencies; used by every module of the block.
package qrff_pkg;

  // Width of position and run counters
  localparam int unsigned POS_BITS = 16;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned WIDE_W   = (POS_BITS > OUT_W) ? POS_BITS : OUT_W;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [OUT_W-1:0]    OUT_MAX = {OUT_W{1'b1}};

  localparam int unsigned BASE_W   = 3;
  localparam int unsigned QUAL_W   = 8;
  localparam int unsigned MINLEN_W = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Reset values of the configuration registers
  localparam logic [QUAL_W-1:0]   MIN_QUALITY_RST    = 8'd20;
  localparam logic [MINLEN_W-1:0] MIN_RUN_LENGTH_RST = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_QUALITY      = 2'd0,
    CFG_MIN_RUN_LENGTH   = 2'd1,
    CFG_SPLIT_MODE       = 2'd2,
    CFG_HOMOPOLYMER_MODE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [QUAL_W-1:0]   min_quality;
    logic [MINLEN_W-1:0] min_run_length;
    logic                split_mode;
    logic                homopolymer_mode;
  } cfg_t;

  typedef struct packed {
    logic [BASE_W-1:0] base_code;
    logic [QUAL_W-1:0] quality;
    logic              read_last;
  } item_t;

  typedef struct packed {
    logic             fragment_valid;
    logic [OUT_W-1:0] fragment_start;
    logic [OUT_W-1:0] fragment_length;
    logic [OUT_W-1:0] fragment_number;
    logic             read_end;
    logic             read_kept;
  } result_t;

  // Clip a position-width value to the 16-bit output range
  function automatic logic [OUT_W-1:0] clip_out(input logic [POS_BITS-1:0] v);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(v);
    if (wide > WIDE_W'(OUT_MAX)) begin
      return OUT_MAX;
    end
    return wide[OUT_W-1:0];
  endfunction

endpackage

>>> rtl/core/qrff_cfg_regs.sv
// Configuration registers of the quality run fragment filter.
// Depends on qrff_pkg.
module qrff_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [qrff_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [qrff_pkg::CFG_W-1:0]     cfg_data_i,
  output qrff_pkg::cfg_t                 cfg_o
);

  qrff_pkg::cfg_t   cfg_d, cfg_q;
  qrff_pkg::cfg_idx_e idx;

  assign idx = qrff_pkg::cfg_idx_e'(cfg_index_i);

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (idx)
        qrff_pkg::CFG_MIN_QUALITY:
          cfg_d.min_quality = cfg_data_i[qrff_pkg::QUAL_W-1:0];
        qrff_pkg::CFG_MIN_RUN_LENGTH:
          cfg_d.min_run_length = cfg_data_i[qrff_pkg::MINLEN_W-1:0];
        qrff_pkg::CFG_SPLIT_MODE:
          cfg_d.split_mode = cfg_data_i[0];
        qrff_pkg::CFG_HOMOPOLYMER_MODE:
          cfg_d.homopolymer_mode = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_quality      <= qrff_pkg::MIN_QUALITY_RST;
      cfg_q.min_run_length   <= qrff_pkg::MIN_RUN_LENGTH_RST;
      cfg_q.split_mode       <= 1'b0;
      cfg_q.homopolymer_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/qrff_run_core.sv
// Input register, per-read run state and single-pass fragment decision.
// Depends on qrff_pkg.
module qrff_run_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qrff_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qrff_pkg::item_t   item_i,
  input  logic              res_ready_i,
  output logic              res_load_o,
  output qrff_pkg::result_t res_o
);

  localparam int unsigned PW = qrff_pkg::POS_BITS;
  localparam int unsigned OW = qrff_pkg::OUT_W;
  localparam int unsigned WW = qrff_pkg::WIDE_W;

  // Input register
  logic            in_valid_d, in_valid_q;
  qrff_pkg::item_t item_q;
  logic            accept, advance;

  // Read state
  logic [PW-1:0]               base_position_d, base_position_q;
  logic [PW-1:0]               run_begin_d, run_begin_q;
  logic [PW-1:0]               run_count_d, run_count_q;
  logic [qrff_pkg::BASE_W-1:0] previous_base_d, previous_base_q;
  logic [OW-1:0]               fragments_found_d, fragments_found_q;
  logic                        read_finished_d, read_finished_q;

  // Decision terms
  logic          active, extend, close, report, emit;
  logic [PW-1:0] count_ext, begin_ext;
  logic [OW-1:0] found_new;

  assign advance    = in_valid_q && res_ready_i;
  assign in_stall_o = in_valid_q && !res_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  // Run extension and close decision
  always_comb begin
    active = !read_finished_q;
    extend = (item_q.quality >= cfg_i.min_quality) ||
             (cfg_i.homopolymer_mode && (run_count_q != '0) &&
              (item_q.base_code == previous_base_q));
    close  = !extend || item_q.read_last;

    count_ext = run_count_q;
    begin_ext = run_begin_q;
    if (extend) begin
      if (run_count_q == '0) begin
        begin_ext = base_position_q;
      end
      if (run_count_q != qrff_pkg::POS_MAX) begin
        count_ext = run_count_q + PW'(1);
      end
    end

    report = active && close && (count_ext != '0) &&
             (WW'(count_ext) >= WW'(cfg_i.min_run_length));

    found_new = fragments_found_q;
    if (report && (fragments_found_q != qrff_pkg::OUT_MAX)) begin
      found_new = fragments_found_q + OW'(1);
    end

    emit = report || item_q.read_last;
  end

  // Result fields
  always_comb begin
    res_o                 = '0;
    res_o.fragment_valid  = report;
    if (report) begin
      res_o.fragment_start  = qrff_pkg::clip_out(begin_ext);
      res_o.fragment_length = qrff_pkg::clip_out(count_ext);
      res_o.fragment_number = fragments_found_q;
    end
    res_o.read_end  = item_q.read_last;
    res_o.read_kept = item_q.read_last && (found_new != '0);
  end

  assign res_load_o = advance && emit;

  // Next read state
  always_comb begin
    base_position_d   = base_position_q;
    run_begin_d       = run_begin_q;
    run_count_d       = run_count_q;
    previous_base_d   = previous_base_q;
    fragments_found_d = fragments_found_q;
    read_finished_d   = read_finished_q;
    if (advance) begin
      if (item_q.read_last) begin
        base_position_d   = '0;
        run_begin_d       = '0;
        run_count_d       = '0;
        previous_base_d   = '0;
        fragments_found_d = '0;
        read_finished_d   = 1'b0;
      end else if (active) begin
        run_begin_d       = begin_ext;
        run_count_d       = close ? '0 : count_ext;
        previous_base_d   = item_q.base_code;
        fragments_found_d = found_new;
        read_finished_d   = report && !cfg_i.split_mode;
        if (base_position_q != qrff_pkg::POS_MAX) begin
          base_position_d = base_position_q + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_position_q   <= '0;
      run_begin_q       <= '0;
      run_count_q       <= '0;
      previous_base_q   <= '0;
      fragments_found_q <= '0;
      read_finished_q   <= 1'b0;
    end else begin
      base_position_q   <= base_position_d;
      run_begin_q       <= run_begin_d;
      run_count_q       <= run_count_d;
      previous_base_q   <= previous_base_d;
      fragments_found_q <= fragments_found_d;
      read_finished_q   <= read_finished_d;
    end
  end

endmodule

>>> rtl/core/qrff_out_reg.sv
// Result register between the run core and the output channel.
// Depends on qrff_pkg.
module qrff_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  qrff_pkg::result_t res_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output qrff_pkg::result_t res_o
);

  logic              valid_d, valid_q;
  qrff_pkg::result_t res_q;

  // Free when empty or when the held item leaves this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/core/quality_run_fragment_filter.sv
// Top level of the quality run fragment filter.
// Depends on qrff_pkg, qrff_cfg_regs, qrff_run_core, qrff_out_reg and the assert macros.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    base_code_i, quality_i, read_last_i
//   out      output     out_valid_o / out_stall_i  fragment_*_o, read_end_o, read_kept_o
//   cfg      input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// One item per cycle unless the output stalls; items cross the input and result registers.
// The run decision is one compare-and-increment pass between the input and result registers.
// Reset clears configuration to defaults and all read state; no clearing pass.
// A stalled result holds the input register, which then stalls the input channel.
`include "quality_run_fragment_filter_assert.svh"

module quality_run_fragment_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [qrff_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [qrff_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [qrff_pkg::BASE_W-1:0]    base_code_i,
  input  logic [qrff_pkg::QUAL_W-1:0]    quality_i,
  input  logic                           read_last_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           fragment_valid_o,
  output logic [qrff_pkg::OUT_W-1:0]     fragment_start_o,
  output logic [qrff_pkg::OUT_W-1:0]     fragment_length_o,
  output logic [qrff_pkg::OUT_W-1:0]     fragment_number_o,
  output logic                           read_end_o,
  output logic                           read_kept_o
);

  qrff_pkg::cfg_t    cfg;
  qrff_pkg::item_t   item;
  qrff_pkg::result_t core_res, out_res;
  logic              res_ready, res_load;

  assign item.base_code = base_code_i;
  assign item.quality   = quality_i;
  assign item.read_last = read_last_i;

  qrff_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  qrff_run_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (item),
    .res_ready_i (res_ready),
    .res_load_o  (res_load),
    .res_o       (core_res)
  );

  qrff_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .res_i       (core_res),
    .ready_o     (res_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign fragment_valid_o  = out_res.fragment_valid;
  assign fragment_start_o  = out_res.fragment_start;
  assign fragment_length_o = out_res.fragment_length;
  assign fragment_number_o = out_res.fragment_number;
  assign read_end_o        = out_res.read_end;
  assign read_kept_o       = out_res.read_kept;

  // Every result carries a fragment or closes a read
  `QRFF_ASSERT_IMPL(a_result_has_cause, clk_i, rst_ni,
    out_valid_o && !fragment_valid_o, read_end_o)
  // Empty fragment fields are zero
  `QRFF_ASSERT_IMPL(a_empty_fields_zero, clk_i, rst_ni,
    out_valid_o && !fragment_valid_o,
    (fragment_start_o == '0) && (fragment_length_o == '0) && (fragment_number_o == '0))
  // Kept flag only on a read end, and a fragment at read end keeps the read
  `QRFF_ASSERT_IMPL(a_kept_on_end, clk_i, rst_ni,
    out_valid_o && (read_kept_o || (fragment_valid_o && read_end_o)),
    read_end_o && read_kept_o)
  // A reported fragment is never empty
  `QRFF_ASSERT_IMPL(a_fragment_nonempty, clk_i, rst_ni,
    out_valid_o && fragment_valid_o, fragment_length_o != '0)

endmodule

>>> verif/testbench.sv
// Self-checking testbench for quality_run_fragment_filter.
// Depends on qrff_pkg and the RTL of the block; predicts each result in its own model.
`timescale 1ns / 1ps

module testbench;
  import qrff_pkg::*;

  localparam logic [BASE_W-1:0] NT_A = 3'd0;
  localparam logic [BASE_W-1:0] NT_C = 3'd1;
  localparam logic [BASE_W-1:0] NT_G = 3'd2;
  localparam logic [BASE_W-1:0] NT_T = 3'd3;
  localparam logic [BASE_W-1:0] NT_N = 3'd4;

  localparam int DRAIN_CYCLES = 6;
  localparam int STALL_LIMIT  = 3000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [BASE_W-1:0]    base_code_i;
  logic [QUAL_W-1:0]    quality_i;
  logic                 read_last_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 fragment_valid_o;
  logic [OUT_W-1:0]     fragment_start_o;
  logic [OUT_W-1:0]     fragment_length_o;
  logic [OUT_W-1:0]     fragment_number_o;
  logic                 read_end_o;
  logic                 read_kept_o;

  quality_run_fragment_filter uut (.*);

  always #5 clk_i = ~clk_i;

  // Settings mirrored from the register writes
  logic [QUAL_W-1:0]   q_min;
  logic [MINLEN_W-1:0] len_min;
  logic                split_on;
  logic                homo_on;

  // Per-read trimming state
  logic [POS_BITS-1:0] pos;
  logic [POS_BITS-1:0] run_start;
  logic [POS_BITS-1:0] run_len;
  logic [BASE_W-1:0]   prev_base;
  logic [OUT_W-1:0]    frag_cnt;
  logic                read_done;

  result_t run_reports[$];
  int      mismatch_count = 0;
  int      send_gap_max = 0;
  int      recv_gap_max = 0;
  int      stall_hold_cycles = 0;
  int      recv_wait = 0;
  int      idle_cycles = 0;
  bit      in_taken = 0;
  bit      out_taken = 0;

  function automatic logic [OUT_W-1:0] sat16(input logic [POS_BITS-1:0] v);
    return (v > POS_BITS'(OUT_MAX)) ? OUT_MAX : OUT_W'(v);
  endfunction

  // Advance the trimming state by one base; returns 1 when a result is due
  function automatic bit predict_run_report(input logic [BASE_W-1:0] b,
                                            input logic [QUAL_W-1:0] q,
                                            input logic l, output result_t r);
    bit                  extend;
    bit                  close;
    bit                  hit;
    logic [POS_BITS-1:0] f_start;
    logic [POS_BITS-1:0] f_len;
    logic [OUT_W-1:0]    f_num;
    hit = 0;
    f_start = '0;
    f_len = '0;
    f_num = '0;
    r = '0;
    if (!read_done) begin
      extend = (q >= q_min) || (homo_on && run_len != 0 && b == prev_base);
      close = !extend || l;
      if (extend) begin
        if (run_len == 0) run_start = pos;
        if (run_len != POS_MAX) run_len = run_len + 1'b1;
      end
      if (close) begin
        if (run_len != 0 && run_len >= len_min) begin
          hit = 1;
          f_start = run_start;
          f_len = run_len;
          f_num = frag_cnt;
          if (frag_cnt != OUT_MAX) frag_cnt = frag_cnt + 1'b1;
          if (!split_on) read_done = 1;
        end
        run_len = '0;
      end
      prev_base = b;
      if (pos != POS_MAX) pos = pos + 1'b1;
    end
    if (!hit && !l) return 0;
    r.fragment_valid = hit;
    r.fragment_start = sat16(f_start);
    r.fragment_length = sat16(f_len);
    r.fragment_number = f_num;
    if (l) begin
      r.read_end = 1;
      r.read_kept = (frag_cnt != 0);
      pos = '0;
      run_start = '0;
      run_len = '0;
      prev_base = '0;
      frag_cnt = '0;
      read_done = 0;
    end
    return 1;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [OUT_W-1:0] got,
                               input logic [OUT_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Handshake monitor: sampled mid-cycle, the item moves at the next rising edge
  always @(negedge clk_i) begin
    result_t want;
    in_taken = 0;
    out_taken = 0;
    if (rst_ni) begin
      in_taken = in_valid_i && !in_stall_o;
      out_taken = out_valid_o && !out_stall_i;
      if (out_taken) begin
        if (run_reports.size() == 0) begin
          report_mismatch("result with no expected result pending");
        end else begin
          want = run_reports.pop_front();
          compare_field("fragment_valid", OUT_W'(fragment_valid_o), OUT_W'(want.fragment_valid));
          compare_field("fragment_start", fragment_start_o, want.fragment_start);
          compare_field("fragment_length", fragment_length_o, want.fragment_length);
          compare_field("fragment_number", fragment_number_o, want.fragment_number);
          compare_field("read_end", OUT_W'(read_end_o), OUT_W'(want.read_end));
          compare_field("read_kept", OUT_W'(read_kept_o), OUT_W'(want.read_kept));
        end
      end
    end
  end

  // Receiver: random wait per item, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (out_taken) recv_wait = $urandom_range(0, recv_gap_max);
    if (stall_hold_cycles > 0) begin
      stall_hold_cycles--;
      out_stall_i <= 1'b1;
    end else if (recv_wait > 0) begin
      recv_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog on cycles without any item moving
  always @(posedge clk_i) begin
    if (!rst_ni || in_taken || out_taken) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Offer one base, wait for it to be taken, then predict its result
  task automatic send_base(input logic [BASE_W-1:0] b, input logic [QUAL_W-1:0] q,
                           input logic l);
    int      gap;
    bit      taken;
    result_t r;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    base_code_i <= b;
    quality_i <= q;
    read_last_i <= l;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    if (predict_run_report(b, q, l, r)) run_reports.push_back(r);
  endtask

  // Stop offering and let every pending result come out
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (run_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  // Write all four registers while idle; unused upper data bits carry junk
  task automatic apply_settings(input logic [QUAL_W-1:0] q, input logic [MINLEN_W-1:0] len,
                                input logic split, input logic homo);
    wait_idle();
    write_reg(CFG_MIN_QUALITY, {8'($urandom), q});
    write_reg(CFG_MIN_RUN_LENGTH, len);
    write_reg(CFG_SPLIT_MODE, {15'($urandom), split});
    write_reg(CFG_HOMOPOLYMER_MODE, {15'($urandom), homo});
    cfg_we_i <= 1'b0;
    q_min = q;
    len_min = len;
    split_on = split;
    homo_on = homo;
  endtask

  // Reset settings: score 20 is the boundary, 50 the shortest fragment
  task automatic test_reset_defaults();
    int i;
    send_gap_max = 3;
    recv_gap_max = 3;
    for (i = 0; i < 50; i++) send_base(BASE_W'($urandom_range(0, 4)), 8'd20, i == 49);
    for (i = 0; i < 49; i++) send_base(NT_G, 8'd255, 1'b0);
    send_base(NT_T, 8'd19, 1'b1);
  endtask

  task automatic test_directed();
    send_gap_max = 17;
    recv_gap_max = 17;
    // fragment closed by the read end itself
    apply_settings(8'd30, 16'd3, 1'b0, 1'b0);
    send_base(NT_A, 8'd30, 1'b0);
    send_base(NT_C, 8'd31, 1'b0);
    send_base(NT_G, 8'd255, 1'b1);
    // truncate mode: rest of the read skipped after the first fragment
    send_base(NT_T, 8'd29, 1'b0);
    send_base(NT_N, 8'd30, 1'b0);
    send_base(NT_A, 8'd40, 1'b0);
    send_base(NT_C, 8'd50, 1'b0);
    send_base(NT_G, 8'd0, 1'b0);
    send_base(NT_T, 8'd99, 1'b0);
    send_base(NT_A, 8'd99, 1'b1);
    // single-base read with nothing kept
    send_base(NT_A, 8'd0, 1'b1);
    // homopolymer repeats, raw codes above N, repeat with no open run
    apply_settings(8'd2, 16'd2, 1'b1, 1'b1);
    send_base(3'd7, 8'd2, 1'b0);
    send_base(3'd7, 8'd0, 1'b0);
    send_base(3'd7, 8'd1, 1'b0);
    send_base(3'd5, 8'd0, 1'b0);
    send_base(3'd5, 8'd0, 1'b0);
    send_base(3'd6, 8'd255, 1'b0);
    send_base(3'd6, 8'd0, 1'b0);
    send_base(NT_A, 8'd1, 1'b1);
    // length threshold below range: empty runs never report
    apply_settings(8'd255, 16'd0, 1'b1, 1'b0);
    send_base(NT_A, 8'd255, 1'b0);
    send_base(NT_A, 8'd0, 1'b0);
    send_base(NT_A, 8'd0, 1'b0);
    send_base(NT_A, 8'd255, 1'b1);
    apply_settings(8'd255, 16'd1, 1'b0, 1'b0);
    send_base(NT_C, 8'd254, 1'b0);
    send_base(NT_C, 8'd255, 1'b1);
  endtask

  // Receiver holds off while the sender keeps offering one-base reads
  task automatic test_backpressure();
    int i;
    apply_settings(8'd100, 16'd2, 1'b1, 1'b0);
    send_gap_max = 0;
    recv_gap_max = 0;
    stall_hold_cycles = 120;
    for (i = 0; i < 40; i++) send_base(BASE_W'($urandom), 8'($urandom), 1'b1);
    wait_idle();
  endtask

  // Random reads, mostly runs above threshold with repeats mixed in
  task automatic test_random();
    int                  phase;
    int                  sent;
    int                  len;
    int                  i;
    int                  hi_pct;
    int                  rep_pct;
    logic [QUAL_W-1:0]   q;
    logic [MINLEN_W-1:0] mlen;
    logic [BASE_W-1:0]   b;
    for (phase = 0; phase < 8; phase++) begin
      q = 8'($urandom_range(2, 255));
      mlen = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(2, 10));
      case (phase)
        0: apply_settings(8'd2, 16'd2, 1'b0, 1'b0);
        1: apply_settings(8'd255, 16'd65535, 1'b1, 1'b1);
        2: apply_settings(8'd255, 16'd2, 1'b1, 1'b0);
        default: apply_settings(q, mlen, 1'($urandom), 1'($urandom));
      endcase
      send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
      recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
      hi_pct = $urandom_range(60, 95);
      rep_pct = $urandom_range(10, 50);
      b = NT_A;
      sent = 0;
      while (sent < 50) begin
        len = $urandom_range(1, 30);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 99) >= rep_pct) begin
            b = ($urandom_range(0, 9) == 0) ? BASE_W'($urandom_range(5, 7))
                                            : BASE_W'($urandom_range(0, 4));
          end
          if ($urandom_range(0, 99) < hi_pct) q = 8'($urandom_range(q_min, 255));
          else q = 8'($urandom_range(0, q_min - 1));
          send_base(b, q, i == len - 1);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_MIN_QUALITY;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    base_code_i = '0;
    quality_i = '0;
    read_last_i = 1'b0;
    out_stall_i = 1'b0;
    q_min = MIN_QUALITY_RST;
    len_min = MIN_RUN_LENGTH_RST;
    split_on = 1'b0;
    homo_on = 1'b0;
    pos = '0;
    run_start = '0;
    run_len = '0;
    prev_base = '0;
    frag_cnt = '0;
    read_done = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed();
    test_backpressure();
    test_random();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/qrff_pkg.sv
rtl/core/qrff_cfg_regs.sv
rtl/core/qrff_run_core.sv
rtl/core/qrff_out_reg.sv
rtl/core/quality_run_fragment_filter.sv
verif/testbench.sv
